FILE: sv/sala_pkg.sv
package sala_pkg;

    localparam logic [15:0] POOL_BASE = 16'h8000;
    localparam logic [15:0] POOL_LAST = 16'hfffd;
    localparam logic [15:0] NO_ADDR   = 16'hffff;

    // address-in-use map: 32768 bits held as rows of 64
    localparam int ROW_W    = 64;
    localparam int BIT_W    = 6;
    localparam int MAP_ROWS = 512;
    localparam int ROW_AW   = 9;
    localparam int IDX_W    = 15;
    localparam logic [IDX_W-1:0]  IDX_LAST = 15'd32765;
    localparam logic [ROW_AW-1:0] ROW_LAST = 9'd511;

    localparam logic [1:0] ACT_ALLOC    = 2'd0;
    localparam logic [1:0] ACT_FREE_DEV = 2'd1;
    localparam logic [1:0] ACT_FREE_SA  = 2'd2;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    localparam logic [2:0] ST_RENEWED = 3'd0;
    localparam logic [2:0] ST_NEW     = 3'd1;
    localparam logic [2:0] ST_FREED   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [63:0] dev;
        logic [15:0] sa;
    } t_lease;

    typedef struct packed {
        logic             first;
        logic             last;
        logic             top_row;
        logic [BIT_W-1:0] start_bit;
    } t_scan_ctl;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } t_scan_res;

endpackage

FILE: sv/short_address_lease_allocator_core.sv
// Short address lease allocator. Binds 64-bit device addresses to short
// addresses 0x8000..0xfffd; one result beat per input beat. After reset the
// block clears its memories before taking input. Every action except the
// unused code and a free by a short address outside the pool scans the
// lease table one entry a cycle. A new lease then walks the 512-row
// address-in-use map, reading and then checking each row, further the more
// crowded the pool is past the last address handed out; a free that finds its
// lease reads its map row and then clears its bit. One item is worked at a time.
module short_address_lease_allocator_core
    import sala_pkg::*;
#(
    parameter int LEASES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_hw_addr,
    input  logic [15:0] i_short_addr,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_given_addr,
    output logic [2:0]  o_status
);

    localparam int LW    = (LEASES > 1) ? $clog2(LEASES) : 1;
    localparam int CLR_N = (LEASES > MAP_ROWS) ? LEASES : MAP_ROWS;
    localparam int CW    = $clog2(CLR_N) + 1;
    localparam int LEASE_W = $bits(t_lease);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MRD   = 3'd3;
    localparam logic [2:0] S_MCHK  = 3'd4;
    localparam logic [2:0] S_FRD   = 3'd5;
    localparam logic [2:0] S_FWR   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_clr, n_clr;
    logic [1:0]        r_act, n_act;
    logic [63:0]       r_dev, n_dev;
    logic [15:0]       r_sa, n_sa;
    logic [LW-1:0]     r_ridx, n_ridx;
    logic              r_issue, n_issue;
    logic [LW-1:0]     r_chk, n_chk;
    logic              r_chk_v, n_chk_v;
    logic              r_hit, n_hit;
    logic [LW-1:0]     r_hit_idx, n_hit_idx;
    logic [15:0]       r_hit_sa, n_hit_sa;
    logic              r_free, n_free;
    logic [LW-1:0]     r_free_idx, n_free_idx;
    logic [IDX_W-1:0]  r_last, n_last;
    logic [IDX_W-1:0]  r_start, n_start;
    logic [ROW_AW-1:0] r_row, n_row;
    logic [ROW_AW:0]   r_rows, n_rows;
    logic [15:0]       r_given, n_given;
    logic [2:0]        r_st, n_st;
    logic              r_ov, n_ov;
    logic [15:0]       r_oga, n_oga;
    logic [2:0]        r_ost, n_ost;

    logic              l_we;
    logic [LW-1:0]     l_waddr, l_raddr;
    t_lease            l_wdata, l_rdata;
    logic [LEASE_W-1:0] l_rbits;
    logic              m_we;
    logic [ROW_AW-1:0] m_waddr, m_raddr;
    logic [ROW_W-1:0]  m_wdata, m_rdata;
    t_scan_ctl         sc_ctl;
    t_scan_res         sc_res;
    logic              ent_match;

    sala_ram #(.WIDTH(LEASE_W), .DEPTH(LEASES), .AW(LW)) u_lease_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rbits)
    );
    assign l_rdata = t_lease'(l_rbits);

    sala_ram #(.WIDTH(ROW_W), .DEPTH(MAP_ROWS), .AW(ROW_AW)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    assign sc_ctl.first     = (r_rows == '0);
    assign sc_ctl.last      = (r_rows == (ROW_AW+1)'(MAP_ROWS));
    assign sc_ctl.top_row   = (r_row == ROW_LAST);
    assign sc_ctl.start_bit = r_start[BIT_W-1:0];

    sala_rowscan u_rowscan (
        .i_row (m_rdata),
        .i_ctl (sc_ctl),
        .o_res (sc_res)
    );

    assign ent_match = l_rdata.valid &&
        ((r_act == ACT_FREE_SA) ? (l_rdata.sa == r_sa) : (l_rdata.dev == r_dev));

    always_comb begin
        n_state = r_state;    n_clr = r_clr;       n_act = r_act;
        n_dev = r_dev;        n_sa = r_sa;         n_ridx = r_ridx;
        n_issue = r_issue;    n_chk = r_ridx;      n_chk_v = r_issue;
        n_hit = r_hit;        n_hit_idx = r_hit_idx; n_hit_sa = r_hit_sa;
        n_free = r_free;      n_free_idx = r_free_idx; n_last = r_last;
        n_start = r_start;    n_row = r_row;       n_rows = r_rows;
        n_given = r_given;    n_st = r_st;         n_ov = r_ov;
        n_oga = r_oga;        n_ost = r_ost;
        l_we = 1'b0;          l_waddr = r_hit_idx; l_wdata = '0;
        l_raddr = r_ridx;
        m_we = 1'b0;          m_waddr = r_row;     m_wdata = '0;
        m_raddr = r_row;

        if (r_ov && !i_out_stall) n_ov = 1'b0;

        case (r_state)
            S_CLEAR: begin
                m_we    = (r_clr < CW'(MAP_ROWS));
                m_waddr = r_clr[ROW_AW-1:0];
                l_we    = (r_clr < CW'(LEASES));
                l_waddr = r_clr[LW-1:0];
                n_clr   = r_clr + 1'b1;
                if (r_clr == CW'(CLR_N - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act   = i_action;
                    n_dev   = i_hw_addr;
                    n_sa    = i_short_addr;
                    n_given = NO_ADDR;
                    n_st    = ST_UNKNOWN;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_ridx  = '0;
                    n_issue = 1'b1;
                    n_chk_v = 1'b0;
                    if (i_action == ACT_ALLOC || i_action == ACT_FREE_DEV ||
                        (i_action == ACT_FREE_SA && i_short_addr >= POOL_BASE &&
                         i_short_addr <= POOL_LAST)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_issue = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    if (r_ridx == LW'(LEASES - 1)) n_issue = 1'b0;
                    else n_ridx = r_ridx + 1'b1;
                end
                if (r_chk_v) begin
                    if (ent_match && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_chk;
                        n_hit_sa  = l_rdata.sa;
                    end
                    if (!l_rdata.valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_chk;
                    end
                    if (r_chk == LW'(LEASES - 1)) begin
                        n_issue = 1'b0;
                        n_chk_v = 1'b0;
                        if (r_act == ACT_ALLOC) begin
                            if (n_hit) begin
                                n_given = n_hit_sa;
                                n_st    = ST_RENEWED;
                                n_state = S_OUT;
                            end else if (!n_free) begin
                                n_st    = ST_FULL;
                                n_state = S_OUT;
                            end else begin
                                // search starts just after the last address given
                                n_start = (r_last == IDX_LAST) ? '0 : r_last + 1'b1;
                                n_row   = n_start[IDX_W-1:BIT_W];
                                n_rows  = '0;
                                n_state = S_MRD;
                            end
                        end else if (n_hit) begin
                            n_state = S_FRD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_MRD: begin
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (sc_res.found) begin
                    m_we    = 1'b1;
                    m_wdata = m_rdata | (ROW_W'(1) << sc_res.bit_idx);
                    l_we    = 1'b1;
                    l_waddr = r_free_idx;
                    l_wdata.valid = 1'b1;
                    l_wdata.dev   = r_dev;
                    l_wdata.sa    = {1'b1, r_row, sc_res.bit_idx};
                    n_last  = {r_row, sc_res.bit_idx};
                    n_given = {1'b1, r_row, sc_res.bit_idx};
                    n_st    = ST_NEW;
                    n_state = S_OUT;
                end else if (sc_ctl.last) begin
                    n_st    = ST_FULL;
                    n_state = S_OUT;
                end else begin
                    n_row   = (r_row == ROW_LAST) ? '0 : r_row + 1'b1;
                    n_rows  = r_rows + 1'b1;
                    n_state = S_MRD;
                end
            end
            S_FRD: begin
                m_raddr = r_hit_sa[IDX_W-1:BIT_W];
                n_state = S_FWR;
            end
            S_FWR: begin
                m_we    = (r_hit_sa >= POOL_BASE) && (r_hit_sa <= POOL_LAST);
                m_waddr = r_hit_sa[IDX_W-1:BIT_W];
                m_wdata = m_rdata & ~(ROW_W'(1) << r_hit_sa[BIT_W-1:0]);
                l_we    = 1'b1;
                l_waddr = r_hit_idx;
                l_wdata = '0;
                n_st    = ST_FREED;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_oga   = r_given;
                    n_ost   = r_st;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_issue <= 1'b0;
            r_chk_v <= 1'b0;
            r_last  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_issue <= n_issue;
            r_chk_v <= n_chk_v;
            r_last  <= n_last;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;           r_dev <= n_dev;         r_sa <= n_sa;
        r_ridx <= n_ridx;         r_chk <= n_chk;
        r_hit <= n_hit;           r_hit_idx <= n_hit_idx; r_hit_sa <= n_hit_sa;
        r_free <= n_free;         r_free_idx <= n_free_idx;
        r_start <= n_start;       r_row <= n_row;         r_rows <= n_rows;
        r_given <= n_given;       r_st <= n_st;
        r_oga <= n_oga;           r_ost <= n_ost;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_given_addr = r_oga;
    assign o_status     = r_ost;

endmodule

FILE: sv/sala_ram.sv
module sala_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/sala_rowscan.sv
module sala_rowscan
    import sala_pkg::*;
(
    input  logic [ROW_W-1:0] i_row,
    input  t_scan_ctl        i_ctl,
    output t_scan_res        o_res
);

    logic [ROW_W-1:0] busy;

    always_comb begin
        busy = i_row;
        for (int b = 0; b < ROW_W; b++) begin
            // first visit skips bits before the start, the wrap visit covers only them
            if (i_ctl.first && (BIT_W'(b) < i_ctl.start_bit)) busy[b] = 1'b1;
            if (i_ctl.last && (BIT_W'(b) >= i_ctl.start_bit)) busy[b] = 1'b1;
        end
        // 0xfffe and 0xffff are not in the pool
        if (i_ctl.top_row) begin
            busy[ROW_W-1] = 1'b1;
            busy[ROW_W-2] = 1'b1;
        end
        o_res = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (!busy[b]) begin
                o_res.found   = 1'b1;
                o_res.bit_idx = BIT_W'(b);
            end
        end
    end

endmodule

FILE: sv/sala_chk.sv
module sala_chk
    import sala_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_given_addr,
    input logic [2:0]  o_status
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a beat is still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result beat dropped");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_FULL))
        else $error("status code out of range");

    a_given_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_RENEWED || o_status == ST_NEW)) |->
        (o_given_addr >= POOL_BASE && o_given_addr <= POOL_LAST))
        else $error("granted address outside pool");

    a_given_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FREED || o_status == ST_UNKNOWN ||
         o_status == ST_FULL)) |-> (o_given_addr == NO_ADDR))
        else $error("address given without a lease");

endmodule

bind short_address_lease_allocator_core sala_chk u_sala_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_given_addr (o_given_addr),
    .o_status     (o_status)
);
